// ===== hw/rtl/mbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbsf_pkg: shared types and constants of the midi byte stream framer
// byte codes, the status length table and the queue entry format
// ----------------------------------------------------------------------------
package mbsf_pkg;

    localparam logic [7:0] STATUS_MASK = 8'h80;
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    // message length by status bits 6:4 (8x..Fx)
    localparam logic [1:0] LEN_TABLE [8] = '{2'd3, 2'd3, 2'd3, 2'd3,
                                             2'd2, 2'd2, 2'd3, 2'd1};

    // one result item as it travels from the front end to the back end
    typedef struct packed {
        logic        kind;
        logic [23:0] payload;
        logic [1:0]  length;
        logic        first;
        logic        last;
    } entry_t;

endpackage

// ===== hw/rtl/mbsf_in_if.sv =====
// ----------------------------------------------------------------------------
// mbsf_in_if: byte request channel
// valid/ready handshake carrying one raw midi byte
// ----------------------------------------------------------------------------
interface mbsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/mbsf_out_if.sv =====
// ----------------------------------------------------------------------------
// mbsf_out_if: message request channel
// valid/ready handshake carrying one framed short message or sysex byte
// ----------------------------------------------------------------------------
interface mbsf_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [23:0] short_message;
    logic [1:0]  message_length;
    logic [7:0]  sysex_byte;
    logic        sysex_first;
    logic        sysex_last;

    modport source (output valid, output out_kind, output short_message,
                    output message_length, output sysex_byte,
                    output sysex_first, output sysex_last, input ready);
    modport sink   (input valid, input out_kind, input short_message,
                    input message_length, input sysex_byte,
                    input sysex_first, input sysex_last, output ready);
endinterface

// ===== hw/rtl/mbsf_front.sv =====
// ----------------------------------------------------------------------------
// mbsf_front: byte classifier and framing state
// decodes each accepted byte, updates framing state, pushes result entries
// ----------------------------------------------------------------------------
module mbsf_front
    import mbsf_pkg::*;
#(
    parameter int SYSEX_LIMIT = 1026
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    output logic       push,
    output entry_t     entry
);

    localparam int PosW = $clog2(SYSEX_LIMIT + 1);
    localparam logic [PosW-1:0] LimitVal = PosW'(SYSEX_LIMIT);

    logic [PosW-1:0] pos_reg, pos_next;
    logic [1:0]      exp_reg, exp_next;
    logic [23:0]     word_reg, word_next;
    logic            sysex_reg, sysex_next;

    logic            restart;
    logic [PosW-1:0] pos_a, pos_inc;
    logic [1:0]      exp_a;
    logic [23:0]     word_a, word_ins;
    logic            sysex_a;
    logic            last;
    logic            result;

    always_comb
    begin
        restart = ((data_byte & STATUS_MASK) != 8'h00) &&
                  !(data_byte == SYSEX_END && sysex_reg);
        pos_a   = restart ? '0 : pos_reg;
        exp_a   = restart ? LEN_TABLE[data_byte[6:4]] : exp_reg;
        word_a  = restart ? 24'h0 : word_reg;
        sysex_a = sysex_reg || (restart && data_byte == SYSEX_START);
        pos_inc = pos_a + PosW'(1);

        // byte lane for the short message
        case (pos_a[1:0])
            2'd0:    word_ins = {16'h0, data_byte};
            2'd1:    word_ins = {8'h0, data_byte, 8'h0};
            default: word_ins = {data_byte, 16'h0};
        endcase

        last       = (data_byte == SYSEX_END) || (pos_inc >= LimitVal);
        pos_next   = pos_a;
        exp_next   = exp_a;
        word_next  = word_a;
        sysex_next = sysex_a;
        result     = 1'b0;
        entry      = '0;

        if (sysex_a)
        begin
            pos_next      = pos_inc;
            sysex_next    = !last;
            exp_next      = last ? 2'd0 : exp_a;
            result        = 1'b1;
            entry.kind    = KIND_SYSEX;
            entry.payload = {16'h0, data_byte};
            entry.first   = (pos_a == '0);
            entry.last    = last;
        end
        else if (exp_a != 2'd0 && pos_a < PosW'(exp_a))
        begin
            pos_next      = pos_inc;
            word_next     = word_a | word_ins;
            result        = (pos_inc == PosW'(exp_a));
            entry.kind    = KIND_SHORT;
            entry.payload = word_a | word_ins;
            entry.length  = exp_a;
        end
    end

    assign push = take && result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            exp_reg   <= 2'd0;
            word_reg  <= 24'h0;
            sysex_reg <= 1'b0;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            exp_reg   <= exp_next;
            word_reg  <= word_next;
            sysex_reg <= sysex_next;
        end
    end

    a_last_ends_sysex: assert property (@(posedge clk) disable iff (!rst_n)
        (push && entry.kind == KIND_SYSEX && entry.last) |=> !sysex_reg)
        else $error("sysex mode still on after last byte");

    a_pos_in_short: assert property (@(posedge clk) disable iff (!rst_n)
        (!sysex_reg && exp_reg != 2'd0) |-> (pos_reg <= PosW'(exp_reg)))
        else $error("short message position beyond expected length");

endmodule

// ===== hw/rtl/mbsf_queue.sv =====
// ----------------------------------------------------------------------------
// mbsf_queue: two-entry result queue
// decouples the front end from the output stage
// ----------------------------------------------------------------------------
module mbsf_queue
    import mbsf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   not_empty,
    output logic   not_full,
    output entry_t head
);

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);

    entry_t            mem_reg [Depth];
    logic [PtrW-1:0]   wr_reg, rd_reg;
    logic [PtrW:0]     count_reg;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != (PtrW + 1)'(Depth));
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + PtrW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PtrW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PtrW + 1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_full |-> (!push || pop))
        else $error("push into full queue");

endmodule

// ===== hw/rtl/mbsf_back.sv =====
// ----------------------------------------------------------------------------
// mbsf_back: output stage
// expands queue entries into message fields and holds them in a register
// ----------------------------------------------------------------------------
module mbsf_back
    import mbsf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         has_entry,
    input  entry_t       head,
    output logic         pop,
    mbsf_out_if.source   messages
);

    logic        valid_reg;
    logic        kind_reg;
    logic [23:0] short_reg;
    logic [1:0]  length_reg;
    logic [7:0]  sysex_reg;
    logic        first_reg;
    logic        last_reg;

    assign pop = has_entry && (!valid_reg || messages.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || messages.ready)
        begin
            valid_reg <= has_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head.kind;
            if (head.kind == KIND_SYSEX)
            begin
                short_reg  <= 24'h0;
                length_reg <= 2'd0;
                sysex_reg  <= head.payload[7:0];
                first_reg  <= head.first;
                last_reg   <= head.last;
            end
            else
            begin
                short_reg  <= head.payload;
                length_reg <= head.length;
                sysex_reg  <= 8'h0;
                first_reg  <= 1'b0;
                last_reg   <= 1'b0;
            end
        end
    end

    assign messages.valid          = valid_reg;
    assign messages.out_kind       = kind_reg;
    assign messages.short_message  = short_reg;
    assign messages.message_length = length_reg;
    assign messages.sysex_byte     = sysex_reg;
    assign messages.sysex_first    = first_reg;
    assign messages.sysex_last     = last_reg;

    a_short_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_SHORT) |-> (length_reg != 2'd0))
        else $error("short message with zero length");

endmodule

// ===== hw/rtl/midi_byte_stream_framer.sv =====
// ----------------------------------------------------------------------------
// midi_byte_stream_framer: midi byte stream to message framer
// frames raw midi bytes into short messages and streamed sysex bytes
// ----------------------------------------------------------------------------
// usage
//   bytes    : one raw midi byte per request (data_byte, bit 7 marks status)
//   messages : one request per completed short message (out_kind 0, packed
//              little-endian in short_message, message_length 1..3) or per
//              sysex byte (out_kind 1, sysex_byte with first/last marks)
//   throughput: one byte per cycle, sustained, as long as messages drains
//   path: a message that completes on an accepted byte is written into the
//              two-entry queue as that byte is taken, then loaded into the
//              output register once the output stage is free
//   stall: when messages is held off, results collect in the queue and the
//              output register; bytes.ready drops only when the queue is full
//   reset: framing state clears (no message open, sysex off), queue and
//              output stage empty; bytes.ready is high right after reset
//   SYSEX_LIMIT sets how many bytes a sysex message may stream before it is
//              closed with the last mark
// ----------------------------------------------------------------------------
module midi_byte_stream_framer
    import mbsf_pkg::*;
#(
    parameter int SYSEX_LIMIT = 1026
)
(
    input  logic        clk,
    input  logic        rst_n,
    mbsf_in_if.sink     bytes,
    mbsf_out_if.source  messages
);

    // front end to queue
    logic   take;
    logic   push;
    entry_t push_entry;

    // queue to back end
    logic   q_not_empty;
    logic   q_not_full;
    logic   pop;
    entry_t head;

    // a byte is taken whenever the queue has room for its possible result
    assign bytes.ready = q_not_full;
    assign take        = bytes.valid && q_not_full;

    // classifier and framing state
    mbsf_front #(
        .SYSEX_LIMIT (SYSEX_LIMIT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (bytes.data_byte),
        .push      (push),
        .entry     (push_entry)
    );

    // decoupling queue
    mbsf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .not_full   (q_not_full),
        .head       (head)
    );

    // field expansion and output register
    mbsf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .has_entry (q_not_empty),
        .head      (head),
        .pop       (pop),
        .messages  (messages)
    );

endmodule
